[hdl/cpps_pkg.sv]
// Shared types, constants and helpers for the closest point pair search core.
package cpps_pkg;

	localparam int MAX_POINTS  = 1024;
	localparam int COORD_WIDTH = 16;
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int PROD_W      = 2 * COORD_WIDTH;
	localparam int DIST_W      = 2 * COORD_WIDTH + 2;
	localparam int OUT_IDX_W   = 10;
	localparam int IN_TDATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * OUT_IDX_W + 7) / 8) * 8;

	localparam logic [DIST_W-1:0] DIST_ONES = '1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic [COORD_WIDTH-1:0]        mag_t;

	// x sits in the lowest bits, matching the stream packing
	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	typedef enum logic [1:0] {
		AX_X,
		AX_Y,
		AX_Z
	} axis_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_START,
		S_PI,
		S_DIFF,
		S_MUL,
		S_CMP,
		S_OUT
	} state_t;

	// magnitude of a - b; fits COORD_WIDTH bits unsigned
	function automatic mag_t abs_diff(input coord_t a, input coord_t b);
		logic signed [COORD_WIDTH:0] d;
		logic signed [COORD_WIDTH:0] n;
		d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
		n = -d;
		return d[COORD_WIDTH] ? n[COORD_WIDTH-1:0] : d[COORD_WIDTH-1:0];
	endfunction

endpackage

[hdl/closest_point_pair_search_core.sv]
// Closest point pair search: point store, pair sequencer and shared squared-distance unit.
// Points are accepted back to back while loading; after the last point the search
//   walks every pair i < j of the N stored points, then the result waits for m_tready.
// Pairs are evaluated one at a time, axis by axis, on the single shared multiplier used once per axis.
// Not ready for new points from the last point until the result transfer completes.
// Reset clears the sequencer and point count; the point store is not cleared.
module closest_point_pair_search_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [cpps_pkg::IN_TDATA_W-1:0]      s_tdata,  // coord_x, coord_y, coord_z
	input  logic                                 s_tlast,  // last_point
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cpps_pkg::OUT_TDATA_W-1:0]     m_tdata,  // first_index, second_index, pad
	output logic                                 m_tuser   // pair_found
);
	import cpps_pkg::*;

	state_t              state_q, state_nx;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    i_q, j_q;
	axis_t               ax_q;
	point_t              pi_q, rd_q;
	mag_t                mag_q;
	logic [PROD_W-1:0]   prod_q;
	logic [DIST_W-1:0]   acc_q, best_q, pair_dist;
	logic [IDX_W-1:0]    bf_q, bs_q;
	logic                found_q;

	point_t              mem [MAX_POINTS];
	logic                wr_en, rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                accept, more_j, more_i, better;
	coord_t              ca, cb;

	assign accept    = s_tvalid && s_tready;
	assign more_j    = ({1'b0, j_q} + CNT_W'(1)) < count_q;
	assign more_i    = ({1'b0, i_q} + CNT_W'(2)) < count_q;
	assign pair_dist = acc_q + DIST_W'(prod_q);
	assign better    = pair_dist < best_q;

	always_comb begin
		unique case (ax_q)
			AX_X: begin
				ca = pi_q.x;
				cb = rd_q.x;
			end
			AX_Y: begin
				ca = pi_q.y;
				cb = rd_q.y;
			end
			AX_Z: begin
				ca = pi_q.z;
				cb = rd_q.z;
			end
			default: begin
				ca = pi_q.z;
				cb = rd_q.z;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_LOAD:  if (accept && s_tlast) state_nx = S_START;
			S_START: state_nx = (count_q < CNT_W'(2)) ? S_OUT : S_PI;
			S_PI:    state_nx = S_DIFF;
			S_DIFF:  state_nx = S_MUL;
			S_MUL:   state_nx = (ax_q == AX_Z) ? S_CMP : S_DIFF;
			S_CMP: begin
				if (more_j)      state_nx = S_DIFF;
				else if (more_i) state_nx = S_PI;
				else             state_nx = S_OUT;
			end
			S_OUT:   if (m_tready) state_nx = S_LOAD;
			default: state_nx = S_LOAD;
		endcase
	end

	// outputs and memory control
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		unique case (state_q)
			S_LOAD: begin
				s_tready = 1'b1;
				wr_en    = accept && (count_q < CNT_W'(MAX_POINTS));
			end
			S_START: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_PI: begin
				rd_en   = 1'b1;
				rd_addr = i_q + IDX_W'(1);
			end
			S_CMP: begin
				if (more_j) begin
					rd_en   = 1'b1;
					rd_addr = j_q + IDX_W'(1);
				end else if (more_i) begin
					rd_en   = 1'b1;
					rd_addr = i_q + IDX_W'(1);
				end
			end
			S_OUT:   m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[count_q[IDX_W-1:0]] <= point_t'(s_tdata[3*COORD_WIDTH-1:0]);
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			ax_q    <= AX_X;
			found_q <= 1'b0;
			bf_q    <= '0;
			bs_q    <= '0;
			best_q  <= DIST_ONES;
			pi_q    <= '0;
			mag_q   <= '0;
			prod_q  <= '0;
			acc_q   <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				S_LOAD: if (wr_en) count_q <= count_q + CNT_W'(1);
				S_START: begin
					best_q  <= DIST_ONES;
					bf_q    <= '0;
					bs_q    <= '0;
					i_q     <= '0;
					found_q <= count_q >= CNT_W'(2);
				end
				S_PI: begin
					pi_q   <= rd_q;
					j_q    <= i_q + IDX_W'(1);
					ax_q   <= AX_X;
					acc_q  <= '0;
					prod_q <= '0;
				end
				S_DIFF: begin
					mag_q <= abs_diff(ca, cb);
					acc_q <= acc_q + DIST_W'(prod_q);
				end
				S_MUL: begin
					prod_q <= PROD_W'(mag_q) * PROD_W'(mag_q);
					unique case (ax_q)
						AX_X:    ax_q <= AX_Y;
						AX_Y:    ax_q <= AX_Z;
						default: ax_q <= AX_X;
					endcase
				end
				S_CMP: begin
					// strict less-than keeps the first pair on ties
					if (better) begin
						best_q <= pair_dist;
						bf_q   <= i_q;
						bs_q   <= j_q;
					end
					if (more_j) begin
						j_q    <= j_q + IDX_W'(1);
						ax_q   <= AX_X;
						acc_q  <= '0;
						prod_q <= '0;
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				S_OUT: if (m_tready) count_q <= '0;
				default: ;
			endcase
		end
	end

	assign m_tdata = OUT_TDATA_W'({OUT_IDX_W'(bs_q), OUT_IDX_W'(bf_q)});
	assign m_tuser = found_q;

	a_not_both_sides: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides active together");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (j_q > i_q))
		else $error("pair indices out of order");

	a_no_pair_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("nonzero indices without a pair");

	a_new_set: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> (s_tready && count_q == '0))
		else $error("set not restarted after result transfer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

endmodule
